### src/cis_pkg.sv
// Shared types and constants for the catapult and intake sequencer.
package cis_pkg;

	// Timing constants, in milliseconds
	localparam int TICK_MS   = 10;
	localparam int SHOT_MS   = 150;
	localparam int SETTLE_MS = 100;

	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration register indexes and reset values
	localparam logic [1:0] CFG_MAX_SPEED   = 2'd0;
	localparam logic [1:0] CFG_INTAKE_GAIN = 2'd1;
	localparam logic [1:0] CFG_ROLLER_GAIN = 2'd2;

	localparam logic [9:0]  RESET_MAX_SPEED = 10'd200;
	localparam logic [15:0] RESET_GAIN      = 16'd256;

	// Fractions of top speed: n / 100 as (n * PCT_RECIP) >> PCT_SHIFT, exact below 2^17
	localparam int PRIME_PCT = 85;
	localparam int SHOOT_PCT = 80;
	localparam int PCT_RECIP = 167773;
	localparam int PCT_SHIFT = 24;

	localparam logic [9:0] RESET_PRIME_MAG = 10'(200 * PRIME_PCT / 100);
	localparam logic [9:0] RESET_SHOOT_MAG = 10'(200 * SHOOT_PCT / 100);

	localparam logic signed [15:0] SHOT_MV = -16'sd2400;

	typedef enum logic [3:0] {
		FN_TICK         = 4'd0,
		FN_HOLD         = 4'd1,
		FN_PRIME        = 4'd2,
		FN_SHOOT        = 4'd3,
		FN_CATA_DEG     = 4'd4,
		FN_ROLLER_DEG   = 4'd5,
		FN_ROLLER_TIME  = 4'd6,
		FN_INTAKE_TIME  = 4'd7,
		FN_INTAKE_SPEED = 4'd8,
		FN_ROLLER_SPEED = 4'd9,
		FN_STOP         = 4'd10,
		FN_BOOST        = 4'd11
	} func_t;

	typedef enum logic [2:0] {
		M_HOLD        = 3'd0,
		M_PRIME       = 3'd1,
		M_SHOOT       = 3'd2,
		M_CATA_DEG    = 3'd3,
		M_INTAKE_DEG  = 3'd4,
		M_INTAKE_TIME = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_SETTLE = 2'd1,
		PH_SHOT   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DRV_NONE = 2'd0,
		DRV_VEL  = 2'd1,
		DRV_VOLT = 2'd2
	} drive_t;

	typedef struct packed {
		logic [9:0]  max_speed;
		logic [15:0] intake_gain;
		logic [15:0] roller_gain;
	} cis_cfg_t;

	// One classified transaction as it sits in the queue
	typedef struct packed {
		func_t              op;
		logic               lim;
		logic signed [31:0] pos;
		logic signed [12:0] spd;
		logic signed [20:0] amt;
		logic signed [15:0] scaled;
	} cis_item_t;

	typedef struct packed {
		drive_t             drive_mode;
		logic signed [15:0] drive_value;
		logic               brake_coast;
		logic               valve_on;
		logic               tare_pulse;
		logic               primed;
		mode_t              mode_out;
	} cis_result_t;

endpackage

### src/cis_front.sv
// Intake front end: decodes the function code and scales the speed argument.
module cis_front import cis_pkg::*; (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic               limit_pressed,
	input  logic signed [31:0] position,
	input  logic signed [12:0] speed_arg,
	input  logic signed [20:0] amount_arg,
	input  cis_cfg_t           cfg,
	output logic               push_valid,
	input  logic               push_ready,
	output cis_item_t          push_data
);

	func_t              op;
	logic [15:0]        gain;
	logic signed [29:0] prod;
	logic [29:0]        pabs;
	logic [21:0]        mag;
	logic signed [15:0] scaled;

	assign op = func_t'(func);

	// Roller time and roller speed commands use the roller ratio, everything else the intake ratio
	always_comb begin
		case (op) inside
			FN_ROLLER_TIME, FN_ROLLER_SPEED: gain = cfg.roller_gain;
			default:                         gain = cfg.intake_gain;
		endcase
	end

	// speed * gain / 256, truncated toward zero, saturated to 16 bits
	always_comb begin
		prod = $signed({{17{speed_arg[12]}}, speed_arg}) * $signed({14'd0, gain});
		pabs = prod[29] ? 30'(-prod) : 30'(prod);
		mag  = pabs[29:8];
		if (prod[29]) begin
			scaled = (mag > 22'd32768) ? 16'sh8000 : 16'(22'd0 - mag);
		end else begin
			scaled = (mag > 22'd32767) ? 16'sh7FFF : $signed(mag[15:0]);
		end
	end

	assign push_valid       = in_valid;
	assign in_ready         = push_ready;
	assign push_data.op     = op;
	assign push_data.lim    = limit_pressed;
	assign push_data.pos    = position;
	assign push_data.spd    = speed_arg;
	assign push_data.amt    = amount_arg;
	assign push_data.scaled = scaled;

endmodule

### src/cis_queue.sv
// Short transaction queue between front and back.
module cis_queue import cis_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  cis_item_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output cis_item_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cis_item_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= CW'(count_q + 1'b1);
			else if (do_pop && !do_push) count_q <= CW'(count_q - 1'b1);
		end
	end

endmodule

### src/cis_back.sv
// Execution back end: mode sequencer state, per-transaction update and result register.
module cis_back import cis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cis_cfg_t    cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cis_item_t   item,
	output logic        out_valid,
	input  logic        out_ready,
	output cis_result_t result
);

	localparam int NW = 17;
	localparam int PRW = 35;

	mode_t              mode_q, mode_d;
	phase_t             phase_q, phase_d;
	logic [7:0]         phase_ms_q, phase_ms_d;
	logic               primed_q, primed_d;
	logic signed [15:0] intake_q, intake_d;
	logic signed [12:0] cata_q, cata_d;
	logic signed [20:0] target_q, target_d;
	logic signed [21:0] run_q, run_d;
	logic signed [20:0] boost_q, boost_d;
	logic               valve_q, valve_d;
	logic               coast_q, coast_d;

	logic [9:0]         prime_mag_q, shoot_mag_q;
	logic [NW-1:0]      n_prime, n_shoot;
	logic [PRW-1:0]     p_prime, p_shoot;

	logic               out_valid_q;
	cis_result_t        result_q, res;
	logic               take;

	logic [8:0]         phase_sum;
	logic [7:0]         bumped;
	logic [20:0]        bt_pos;
	logic               bt_ge_shot;
	logic [7:0]         valve_thresh;
	logic signed [31:0] target_ext;
	logic signed [15:0] prime_neg, shoot_neg;

	function automatic logic signed [15:0] mag16(input logic signed [15:0] v);
		if (v == 16'sh8000) return 16'sh7FFF;
		return v[15] ? -v : v;
	endfunction

	// Fraction-of-top-speed registers, refreshed every cycle from the config
	always_comb begin
		n_prime = NW'(cfg.max_speed) * NW'(PRIME_PCT);
		n_shoot = NW'(cfg.max_speed) * NW'(SHOOT_PCT);
		p_prime = PRW'(n_prime) * PRW'(PCT_RECIP);
		p_shoot = PRW'(n_shoot) * PRW'(PCT_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_mag_q <= RESET_PRIME_MAG;
			shoot_mag_q <= RESET_SHOOT_MAG;
		end else begin
			prime_mag_q <= p_prime[PCT_SHIFT +: 10];
			shoot_mag_q <= p_shoot[PCT_SHIFT +: 10];
		end
	end

	assign take      = pop_valid && pop_ready;
	assign pop_ready = !out_valid_q || out_ready;

	// Helpers shared by the tick arms
	always_comb begin
		phase_sum    = {1'b0, phase_ms_q} + 9'(TICK_MS);
		bumped       = (phase_sum > 9'd255) ? 8'hFF : phase_sum[7:0];
		bt_pos       = boost_q[20] ? '0 : boost_q;
		bt_ge_shot   = (bt_pos >= 21'(SHOT_MS));
		valve_thresh = 8'(SHOT_MS) - bt_pos[7:0];
		target_ext   = {{11{target_q[20]}}, target_q};
		prime_neg    = 16'sd0 - $signed({6'd0, prime_mag_q});
		shoot_neg    = 16'sd0 - $signed({6'd0, shoot_mag_q});
	end

	// Next state and result for the transaction at the queue head
	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		phase_ms_d = phase_ms_q;
		primed_d   = primed_q;
		intake_d   = intake_q;
		cata_d     = cata_q;
		target_d   = target_q;
		run_d      = run_q;
		boost_d    = boost_q;
		valve_d    = valve_q;
		coast_d    = coast_q;
		res.drive_mode  = DRV_NONE;
		res.drive_value = '0;
		res.tare_pulse  = 1'b0;

		unique case (item.op) inside
			FN_TICK: begin
				unique case (mode_q)
					M_HOLD: begin
						res.drive_mode  = DRV_VEL;
						res.drive_value = mag16(intake_q);
					end
					M_PRIME: begin
						if (phase_q == PH_SETTLE) begin
							phase_ms_d = bumped;
							if (bumped >= 8'(SETTLE_MS)) begin
								coast_d    = 1'b1;
								mode_d     = M_HOLD;
								phase_d    = PH_NORMAL;
								phase_ms_d = '0;
							end
						end else begin
							res.drive_mode  = DRV_VEL;
							res.drive_value = prime_neg;
							if (item.lim) begin
								primed_d        = 1'b1;
								coast_d         = 1'b0;
								res.drive_value = '0;
								phase_d         = PH_SETTLE;
								phase_ms_d      = '0;
							end
						end
					end
					M_SHOOT: begin
						if (phase_q == PH_SHOT) begin
							phase_ms_d = bumped;
							if (!bt_ge_shot && bumped >= valve_thresh) valve_d = 1'b1;
							if (bumped >= 8'(SHOT_MS)) begin
								valve_d    = 1'b0;
								mode_d     = primed_q ? M_SHOOT : M_PRIME;
								phase_d    = PH_NORMAL;
								phase_ms_d = '0;
							end
						end else begin
							res.drive_mode = DRV_VEL;
							if (bt_ge_shot) begin
								valve_d         = 1'b1;
								res.drive_value = prime_neg;
							end else begin
								res.drive_value = shoot_neg;
							end
							primed_d = 1'b0;
							if (!item.lim) begin
								res.drive_mode  = DRV_VOLT;
								res.drive_value = SHOT_MV;
								phase_d         = PH_SHOT;
								phase_ms_d      = '0;
							end
						end
					end
					M_CATA_DEG: begin
						if (item.pos < target_ext) begin
							mode_d     = M_HOLD;
							phase_d    = PH_NORMAL;
							phase_ms_d = '0;
						end else begin
							res.drive_mode  = DRV_VEL;
							res.drive_value = -mag16({{3{cata_q[12]}}, cata_q});
						end
					end
					M_INTAKE_DEG: begin
						if (item.pos > target_ext) begin
							intake_d   = '0;
							mode_d     = M_HOLD;
							phase_d    = PH_NORMAL;
							phase_ms_d = '0;
						end else begin
							res.drive_mode  = DRV_VEL;
							res.drive_value = mag16(intake_q);
						end
					end
					M_INTAKE_TIME: begin
						if (!run_q[21] && run_q != '0) begin
							res.drive_mode  = DRV_VEL;
							res.drive_value = mag16(intake_q);
							run_d           = run_q - 22'(TICK_MS);
						end else begin
							intake_d   = '0;
							mode_d     = M_HOLD;
							phase_d    = PH_NORMAL;
							phase_ms_d = '0;
						end
					end
					default: ;
				endcase
			end
			FN_HOLD: begin
				mode_d     = M_HOLD;
				phase_d    = PH_NORMAL;
				phase_ms_d = '0;
			end
			FN_PRIME: begin
				if (!primed_q) begin
					mode_d     = M_PRIME;
					phase_d    = PH_NORMAL;
					phase_ms_d = '0;
				end
			end
			FN_SHOOT: begin
				boost_d    = item.amt;
				mode_d     = M_SHOOT;
				phase_d    = PH_NORMAL;
				phase_ms_d = '0;
			end
			FN_CATA_DEG: begin
				res.tare_pulse = 1'b1;
				cata_d         = item.spd;
				target_d       = item.amt;
				mode_d         = M_CATA_DEG;
				phase_d        = PH_NORMAL;
				phase_ms_d     = '0;
			end
			FN_ROLLER_DEG: begin
				res.tare_pulse = 1'b1;
				intake_d       = {{3{item.spd[12]}}, item.spd};
				target_d       = item.amt;
				mode_d         = M_INTAKE_DEG;
				phase_d        = PH_NORMAL;
				phase_ms_d     = '0;
			end
			FN_ROLLER_TIME, FN_INTAKE_TIME: begin
				intake_d   = item.scaled;
				run_d      = {item.amt[20], item.amt};
				mode_d     = M_INTAKE_TIME;
				phase_d    = PH_NORMAL;
				phase_ms_d = '0;
			end
			FN_INTAKE_SPEED, FN_ROLLER_SPEED: intake_d = item.scaled;
			FN_STOP:  intake_d = '0;
			FN_BOOST: valve_d  = (item.spd != '0);
			default: ;
		endcase

		res.brake_coast = coast_d;
		res.valve_on    = valve_d;
		res.primed      = primed_d;
		res.mode_out    = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_HOLD;
			phase_q    <= PH_NORMAL;
			phase_ms_q <= '0;
			primed_q   <= 1'b0;
			intake_q   <= '0;
			cata_q     <= '0;
			target_q   <= '0;
			run_q      <= '0;
			boost_q    <= '0;
			valve_q    <= 1'b0;
			coast_q    <= 1'b0;
		end else if (take) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			phase_ms_q <= phase_ms_d;
			primed_q   <= primed_d;
			intake_q   <= intake_d;
			cata_q     <= cata_d;
			target_q   <= target_d;
			run_q      <= run_d;
			boost_q    <= boost_d;
			valve_q    <= valve_d;
			coast_q    <= coast_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) result_q <= res;
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

### src/catapult_intake_sequencer_core.sv
// Top level of the catapult and intake sequencer: config registers, front, queue, back.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one transaction per 10 ms tick or command:
//    func, limit_pressed, position, speed_arg, amount_arg.
//  - Output channel (out_valid/out_ready) returns exactly one result per input transaction,
//    in order: drive_mode, drive_value, brake_coast, valve_on, tare_pulse, primed, mode_out.
//  - Config port: cfg_we with cfg_addr 0 max_speed, 1 intake_gain, 2 roller_gain, data on
//    cfg_wdata; addr 3 is ignored. Write only while no transaction is in flight.
//  - Path: an accepted transaction is registered in the queue, then, once the back end pops it, in the output register.
//  - Throughput: one transaction per cycle while the output is not stalled; the back-end state
//    update is combinational, so the sequencer state loop sets the rate.
//  - The front end decodes and applies the Q8.8 gain (one 13x16 multiply) on the way into
//    a QUEUE_DEPTH entry queue; the back end pops one entry per cycle into the result
//    register whenever that register is empty or being drained.
//  - Receiver stall: the result register holds, the queue fills, then in_ready drops.
//  - Reset: mode hold, all timers and flags clear, brake hold, config back to
//    max_speed 200 and both gains 256, queue empty.
module catapult_intake_sequencer_core import cis_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic               limit_pressed,
	input  logic signed [31:0] position,
	input  logic signed [12:0] speed_arg,
	input  logic signed [20:0] amount_arg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         drive_mode,
	output logic signed [15:0] drive_value,
	output logic               brake_coast,
	output logic               valve_on,
	output logic               tare_pulse,
	output logic               primed,
	output logic [2:0]         mode_out,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata
);

	cis_cfg_t    cfg_q;
	logic        push_valid, push_ready;
	cis_item_t   push_data;
	logic        pop_valid, pop_ready;
	cis_item_t   pop_data;
	cis_result_t result;

	// Config registers; writes are registered, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed   <= RESET_MAX_SPEED;
			cfg_q.intake_gain <= RESET_GAIN;
			cfg_q.roller_gain <= RESET_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MAX_SPEED:   cfg_q.max_speed   <= cfg_wdata[9:0];
				CFG_INTAKE_GAIN: cfg_q.intake_gain <= cfg_wdata;
				CFG_ROLLER_GAIN: cfg_q.roller_gain <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cis_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.limit_pressed (limit_pressed),
		.position      (position),
		.speed_arg     (speed_arg),
		.amount_arg    (amount_arg),
		.cfg           (cfg_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	cis_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.item      (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign drive_mode  = result.drive_mode;
	assign drive_value = result.drive_value;
	assign brake_coast = result.brake_coast;
	assign valve_on    = result.valve_on;
	assign tare_pulse  = result.tare_pulse;
	assign primed      = result.primed;
	assign mode_out    = result.mode_out;

	// Tare only comes with a degree-limited move
	a_tare_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tare_pulse |-> mode_out == M_CATA_DEG || mode_out == M_INTAKE_DEG)
		else $error("tare pulse outside a degrees mode");

	// Voltage drive is only the shot run
	a_volt_shot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_mode == DRV_VOLT |-> drive_value == SHOT_MV && mode_out == M_SHOOT)
		else $error("voltage drive outside the shot");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_mode == DRV_NONE |-> drive_value == 16'sd0)
		else $error("drive value set without a drive command");

	// A transaction taken while the output is empty passes through the queue and the result register to the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("accepted transaction did not reach the output");

endmodule

### dv/catapult_intake_sequencer_core_tb.sv
// Self-checking testbench for the catapult and intake sequencer core.
module catapult_intake_sequencer_core_tb;
	import cis_pkg::*;

	// Address 3 of the config port decodes to nothing
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	// Highest function code, outside the defined set
	localparam logic [3:0] FN_UNUSED  = 4'd15;

	localparam int ITEMS_PER_PHASE = 152;
	localparam int NUM_PHASES      = 8;
	localparam int LONG_HOLD_OFF   = 80;
	localparam int DRAIN_LIMIT     = 5000;

	// One input transaction as offered on the input channel
	typedef struct {
		logic [3:0]         func;
		logic               lim;
		logic signed [31:0] pos;
		logic signed [12:0] spd;
		logic signed [20:0] amt;
	} cmd_item_t;

	// One row of the directed table; typed rows carry a hand-written result
	typedef struct {
		cmd_item_t   item;
		bit          typed;
		cis_result_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         func;
	logic               limit_pressed;
	logic signed [31:0] position;
	logic signed [12:0] speed_arg;
	logic signed [20:0] amount_arg;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         drive_mode;
	logic signed [15:0] drive_value;
	logic               brake_coast;
	logic               valve_on;
	logic               tare_pulse;
	logic               primed;
	logic [2:0]         mode_out;
	logic               cfg_we;
	logic [1:0]         cfg_addr;
	logic [15:0]        cfg_wdata;

	// Shadow of the sequencer: config, mode, phase timer, flags, speeds, timers
	int     cfg_max, cfg_igain, cfg_rgain;
	mode_t  st_mode;
	phase_t st_phase;
	int     st_phase_ms;
	bit     st_primed, st_valve, st_coast;
	int     st_intake_spd, st_cata_spd, st_target, st_run_timer, st_boost;

	cis_result_t drive_cmd_q[$];   // motor commands still owed by the block
	cmd_item_t   item_q[$];        // transactions waiting to be offered
	dir_row_t    dir_tab[$];

	int mismatches  = 0;
	bit calm        = 1'b0;        // no idling on either side while set
	int stall_asks  = 0;           // bumped by the sender to ask for a long hold-off

	catapult_intake_sequencer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.limit_pressed (limit_pressed),
		.position      (position),
		.speed_arg     (speed_arg),
		.amount_arg    (amount_arg),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_mode    (drive_mode),
		.drive_value   (drive_value),
		.brake_coast   (brake_coast),
		.valve_on      (valve_on),
		.tare_pulse    (tare_pulse),
		.primed        (primed),
		.mode_out      (mode_out),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int abs_sat(int v);
		int a;
		a = (v < 0) ? -v : v;
		return (a > 32767) ? 32767 : a;
	endfunction

	// Q8.8 gain, truncated toward zero, clipped to 16-bit signed
	function automatic int gain_scale(int spd, int gain);
		longint p, m;
		p = longint'(spd) * longint'(gain);
		m = ((p < 0) ? -p : p) / 256;
		if (p < 0)
			return (m > 32768) ? -32768 : int'(-m);
		return (m > 32767) ? 32767 : int'(m);
	endfunction

	function automatic void bump_phase_ms();
		st_phase_ms = (st_phase_ms + TICK_MS > 255) ? 255 : st_phase_ms + TICK_MS;
	endfunction

	// Any mode change drops a pending settle or shot phase
	function automatic void enter_mode(mode_t m);
		st_mode     = m;
		st_phase    = PH_NORMAL;
		st_phase_ms = 0;
	endfunction

	// Applies one transaction to the shadow state and returns the motor command it causes
	function automatic cis_result_t advance_sequencer(cmd_item_t it);
		cis_result_t r;
		drive_t      dm;
		int          dv, bt;
		bit          tare;
		dm   = DRV_NONE;
		dv   = 0;
		tare = 1'b0;
		case (it.func)
			FN_TICK: begin
				case (st_mode)
					M_HOLD: begin
						dm = DRV_VEL;
						dv = abs_sat(st_intake_spd);
					end
					M_PRIME: begin
						if (st_phase == PH_SETTLE) begin
							// brake held at zero velocity, then let it coast
							bump_phase_ms();
							if (st_phase_ms >= SETTLE_MS) begin
								st_coast = 1'b1;
								enter_mode(M_HOLD);
							end
						end else begin
							dm = DRV_VEL;
							dv = -(cfg_max * PRIME_PCT / 100);
							if (it.lim) begin
								st_primed   = 1'b1;
								st_coast    = 1'b0;
								dv          = 0;
								st_phase    = PH_SETTLE;
								st_phase_ms = 0;
							end
						end
					end
					M_SHOOT: begin
						bt = (st_boost < 0) ? 0 : st_boost;
						if (st_phase == PH_SHOT) begin
							bump_phase_ms();
							if (bt < SHOT_MS && st_phase_ms >= SHOT_MS - bt)
								st_valve = 1'b1;
							if (st_phase_ms >= SHOT_MS) begin
								st_valve = 1'b0;
								enter_mode(st_primed ? M_SHOOT : M_PRIME);
							end
						end else begin
							dm = DRV_VEL;
							if (bt >= SHOT_MS) begin
								st_valve = 1'b1;
								dv = -(cfg_max * PRIME_PCT / 100);
							end else begin
								dv = -(cfg_max * SHOOT_PCT / 100);
							end
							st_primed = 1'b0;
							if (!it.lim) begin
								dm          = DRV_VOLT;
								dv          = SHOT_MV;
								st_phase    = PH_SHOT;
								st_phase_ms = 0;
							end
						end
					end
					M_CATA_DEG: begin
						if (it.pos < st_target) begin
							enter_mode(M_HOLD);
						end else begin
							dm = DRV_VEL;
							dv = -abs_sat(st_cata_spd);
						end
					end
					M_INTAKE_DEG: begin
						if (it.pos > st_target) begin
							st_intake_spd = 0;
							enter_mode(M_HOLD);
						end else begin
							dm = DRV_VEL;
							dv = abs_sat(st_intake_spd);
						end
					end
					M_INTAKE_TIME: begin
						if (st_run_timer > 0) begin
							dm = DRV_VEL;
							dv = abs_sat(st_intake_spd);
							st_run_timer -= TICK_MS;
						end else begin
							st_intake_spd = 0;
							enter_mode(M_HOLD);
						end
					end
					default: ;
				endcase
			end
			FN_HOLD:  enter_mode(M_HOLD);
			FN_PRIME: if (!st_primed) enter_mode(M_PRIME);
			FN_SHOOT: begin
				st_boost = it.amt;
				enter_mode(M_SHOOT);
			end
			FN_CATA_DEG: begin
				tare        = 1'b1;
				st_cata_spd = it.spd;
				st_target   = it.amt;
				enter_mode(M_CATA_DEG);
			end
			FN_ROLLER_DEG: begin
				tare          = 1'b1;
				st_intake_spd = it.spd;
				st_target     = it.amt;
				enter_mode(M_INTAKE_DEG);
			end
			FN_ROLLER_TIME: begin
				st_intake_spd = gain_scale(it.spd, cfg_rgain);
				st_run_timer  = it.amt;
				enter_mode(M_INTAKE_TIME);
			end
			FN_INTAKE_TIME: begin
				st_intake_spd = gain_scale(it.spd, cfg_igain);
				st_run_timer  = it.amt;
				enter_mode(M_INTAKE_TIME);
			end
			FN_INTAKE_SPEED: st_intake_spd = gain_scale(it.spd, cfg_igain);
			FN_ROLLER_SPEED: st_intake_spd = gain_scale(it.spd, cfg_rgain);
			FN_STOP:         st_intake_spd = 0;
			FN_BOOST:        st_valve = (it.spd != 0);
			default: ;      // unused function codes change nothing
		endcase
		r.drive_mode  = dm;
		r.drive_value = 16'(dv);
		r.brake_coast = st_coast;
		r.valve_on    = st_valve;
		r.tare_pulse  = tare;
		r.primed      = st_primed;
		r.mode_out    = st_mode;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic cmd_item_t mk_item(logic [3:0] f, bit l, int p, int s, int a);
		cmd_item_t it;
		it.func = f;
		it.lim  = l;
		it.pos  = p;
		it.spd  = 13'(s);
		it.amt  = 21'(a);
		return it;
	endfunction

	function automatic cis_result_t mk_res(drive_t dm, int dv, bit coast, bit valve, bit tare,
			bit prm, mode_t m);
		cis_result_t r;
		r.drive_mode  = dm;
		r.drive_value = 16'(dv);
		r.brake_coast = coast;
		r.valve_on    = valve;
		r.tare_pulse  = tare;
		r.primed      = prm;
		r.mode_out    = m;
		return r;
	endfunction

	function automatic void add_row(cmd_item_t it, bit typed, cis_result_t r);
		dir_row_t row;
		row.item  = it;
		row.typed = typed;
		row.res   = r;
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	function automatic int rnd_spd();
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	function automatic int rnd_amt();
		return int'($urandom_range(0, 2097151)) - 1048576;
	endfunction

	function automatic bit rnd_bit();
		return bit'($urandom_range(0, 1));
	endfunction

	function automatic void add(logic [3:0] f, bit l, int p, int s, int a);
		item_q.insert(item_q.size(), mk_item(f, l, p, s, a));
	endfunction

	// Ticks carry random content in the fields the sequencer ignores
	function automatic void tick(bit l);
		add(FN_TICK, l, $urandom, rnd_spd(), rnd_amt());
	endfunction

	function automatic void tick_at(int p);
		add(FN_TICK, rnd_bit(), p, rnd_spd(), rnd_amt());
	endfunction

	// Mostly well-formed command sequences, with some noise and broken sequences
	function automatic void build_sequence();
		int kind, n, tgt;
		logic [3:0] f;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				// prime: spin until the switch closes, settle, coast
				add(FN_PRIME, rnd_bit(), $urandom, rnd_spd(), rnd_amt());
				repeat ($urandom_range(0, 3)) tick(1'b0);
				tick(1'b1);
				repeat ($urandom_range(8, 12)) tick(rnd_bit());
			end
			2, 3: begin
				// shoot with a boost window, then the automatic re-prime
				case ($urandom_range(0, 3))
					0:       n = $urandom_range(0, 160);
					1:       n = -int'($urandom_range(1, 1048576));
					2:       n = SHOT_MS;
					default: n = rnd_amt();
				endcase
				add(FN_SHOOT, rnd_bit(), $urandom, rnd_spd(), n);
				repeat ($urandom_range(0, 2)) tick(1'b1);
				tick(1'b0);
				repeat ($urandom_range(14, 17)) tick(rnd_bit());
				repeat ($urandom_range(0, 2)) tick(1'b0);
				tick(1'b1);
				repeat (11) tick(rnd_bit());
			end
			4: begin
				// catapult degrees: encoder walks down past the target
				tgt = int'($urandom_range(0, 400)) - 200;
				add(FN_CATA_DEG, rnd_bit(), $urandom, rnd_spd(), tgt);
				for (int i = 0; i < 7; i++) tick_at(tgt + 30 - 10 * i);
			end
			5: begin
				// roller degrees: encoder walks up past the target
				tgt = int'($urandom_range(0, 400)) - 200;
				add(FN_ROLLER_DEG, rnd_bit(), $urandom, rnd_spd(), tgt);
				for (int i = 0; i < 7; i++) tick_at(tgt - 30 + 10 * i);
			end
			6: begin
				f = rnd_bit() ? FN_ROLLER_TIME : FN_INTAKE_TIME;
				add(f, rnd_bit(), $urandom, rnd_spd(), int'($urandom_range(0, 90)) - 10);
				repeat ($urandom_range(2, 12)) tick(rnd_bit());
			end
			7: begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 4))
						0:       f = FN_INTAKE_SPEED;
						1:       f = FN_ROLLER_SPEED;
						2:       f = FN_STOP;
						3:       f = FN_BOOST;
						default: f = FN_HOLD;
					endcase
					add(f, rnd_bit(), $urandom, rnd_bit() ? rnd_spd() : 0, rnd_amt());
				end
				repeat (2) tick(rnd_bit());
			end
			8: begin
				// noise over the whole function space, unused codes included
				repeat ($urandom_range(1, 6))
					add(4'($urandom_range(0, 15)), rnd_bit(), $urandom, rnd_spd(), rnd_amt());
			end
			default: begin
				// broken sequence: a mode command lands in the middle of a phase
				if (rnd_bit())
					add(FN_PRIME, rnd_bit(), $urandom, rnd_spd(), rnd_amt());
				else
					add(FN_SHOOT, rnd_bit(), $urandom, rnd_spd(), $urandom_range(0, 200));
				tick(rnd_bit());
				repeat ($urandom_range(0, 4)) tick(rnd_bit());
				add(4'($urandom_range(FN_HOLD, FN_INTAKE_TIME)), rnd_bit(), $urandom,
					rnd_spd(), $urandom_range(0, 100));
				repeat (2) tick(rnd_bit());
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one transaction; valid stays up until the block takes it
	task automatic drive_item(cmd_item_t it, bit typed, cis_result_t typed_res);
		cis_result_t want;
		if (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= it.func;
		limit_pressed <= it.lim;
		position      <= it.pos;
		speed_arg     <= it.spd;
		amount_arg    <= it.amt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge
		want = advance_sequencer(it);
		drive_cmd_q.insert(drive_cmd_q.size(), typed ? typed_res : want);
	endtask

	// Config writes go in only with nothing in flight
	task automatic program_cfg(int ms, int ig, int rg, bit poke_unused);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MAX_SPEED;
		cfg_wdata <= 16'(ms);
		@(posedge clk);
		cfg_max   = ms;
		cfg_addr  <= CFG_INTAKE_GAIN;
		cfg_wdata <= 16'(ig);
		@(posedge clk);
		cfg_igain = ig;
		cfg_addr  <= CFG_ROLLER_GAIN;
		cfg_wdata <= 16'(rg);
		@(posedge clk);
		cfg_rgain = rg;
		if (poke_unused) begin
			cfg_addr  <= CFG_UNUSED;
			cfg_wdata <= 16'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Sender pause: wait for every owed result, bounded
	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (drive_cmd_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (drive_cmd_q.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time, drive_cmd_q.size());
			drive_cmd_q.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- receiver

	// Random back-pressure, plus a long hold-off whenever the sender asks for one
	initial begin : receiver
		int hold_left;
		int seen;
		hold_left = 0;
		seen      = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_asks != seen) begin
				seen      = stall_asks;
				hold_left = LONG_HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 9) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : result_check
		cis_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_cmd_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected: mode %0d value %0d", $time,
					drive_mode, drive_value);
			end else begin
				want = drive_cmd_q.pop_front();
				if (want.drive_mode !== drive_mode || want.drive_value !== drive_value ||
						want.brake_coast !== brake_coast || want.valve_on !== valve_on ||
						want.tare_pulse !== tare_pulse || want.primed !== primed ||
						want.mode_out !== mode_out) begin
					mismatches++;
					$write("%0t: mismatch expected drv %0d val %0d coast %0b valve %0b ",
						$time, want.drive_mode, want.drive_value, want.brake_coast,
						want.valve_on);
					$write("tare %0b primed %0b mode %0d / ", want.tare_pulse, want.primed,
						want.mode_out);
					$display("actual drv %0d val %0d coast %0b valve %0b tare %0b primed %0b mode %0d",
						drive_mode, drive_value, brake_coast, valve_on,
						tare_pulse, primed, mode_out);
				end
			end
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin : stimulus
		cis_result_t none_res;
		int          ms, ig, rg;
		int          sent;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = FN_TICK;
		limit_pressed = 1'b0;
		position      = '0;
		speed_arg     = '0;
		amount_arg    = '0;
		cfg_we        = 1'b0;
		cfg_addr      = CFG_MAX_SPEED;
		cfg_wdata     = '0;

		// shadow state at reset
		cfg_max       = RESET_MAX_SPEED;
		cfg_igain     = RESET_GAIN;
		cfg_rgain     = RESET_GAIN;
		st_mode       = M_HOLD;
		st_phase      = PH_NORMAL;
		st_phase_ms   = 0;
		st_primed     = 1'b0;
		st_valve      = 1'b0;
		st_coast      = 1'b0;
		st_intake_spd = 0;
		st_cata_spd   = 0;
		st_target     = 0;
		st_run_timer  = 0;
		st_boost      = 0;

		none_res = mk_res(DRV_NONE, 0, 0, 0, 0, 0, M_HOLD);

		// Directed table: extremes, every function, the listed special cases.
		// Hand results only where they follow directly from reset config (max 200, gains 1.0).
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 1, mk_res(DRV_VEL, 0, 0, 0, 0, 0, M_HOLD));
		add_row(mk_item(FN_INTAKE_SPEED, 0, 0, 4095, 0), 1, none_res);
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 1, mk_res(DRV_VEL, 4095, 0, 0, 0, 0, M_HOLD));
		add_row(mk_item(FN_INTAKE_SPEED, 1, -1, -4096, -1), 1, none_res);
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 1, mk_res(DRV_VEL, 4096, 0, 0, 0, 0, M_HOLD));
		add_row(mk_item(FN_STOP, 0, 0, 0, 0), 1, none_res);
		add_row(mk_item(FN_BOOST, 0, 0, 1, 0), 1, mk_res(DRV_NONE, 0, 0, 1, 0, 0, M_HOLD));
		add_row(mk_item(FN_BOOST, 0, 0, 0, 0), 1, none_res);
		add_row(mk_item(FN_PRIME, 0, 0, 0, 0), 1, mk_res(DRV_NONE, 0, 0, 0, 0, 0, M_PRIME));
		// spinning toward the switch at 85 percent of max
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 1, mk_res(DRV_VEL, -170, 0, 0, 0, 0, M_PRIME));
		add_row(mk_item(FN_TICK, 1, 0, 0, 0), 1, mk_res(DRV_VEL, 0, 0, 0, 0, 1, M_PRIME));
		add_row(mk_item(FN_TICK, 1, 0, 0, 0), 1, mk_res(DRV_NONE, 0, 0, 0, 0, 1, M_PRIME));
		// hold in the middle of the settle drops the phase; brake stays held
		add_row(mk_item(FN_HOLD, 0, 0, 0, 0), 1, mk_res(DRV_NONE, 0, 0, 0, 0, 1, M_HOLD));
		// prime while already primed is ignored
		add_row(mk_item(FN_PRIME, 0, 0, 0, 0), 1, mk_res(DRV_NONE, 0, 0, 0, 0, 1, M_HOLD));
		// negative boost time counts as none
		add_row(mk_item(FN_SHOOT, 0, 0, 0, -1048576), 0, none_res);
		add_row(mk_item(FN_TICK, 1, 0, 0, 0), 0, none_res);
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 0, none_res);
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 0, none_res);
		// shoot again during the shot phase, boost longer than the shot
		add_row(mk_item(FN_SHOOT, 0, 0, 0, 1048575), 0, none_res);
		add_row(mk_item(FN_TICK, 1, 0, 0, 0), 0, none_res);
		add_row(mk_item(FN_CATA_DEG, 1, 0, -4096, -1048576), 0, none_res);
		add_row(mk_item(FN_TICK, 0, 32'sh7fffffff, 0, 0), 0, none_res);
		// falling below the target returns to hold with no drive command
		add_row(mk_item(FN_TICK, 0, 32'sh80000000, 0, 0), 0, none_res);
		add_row(mk_item(FN_ROLLER_DEG, 0, 0, 4095, 1048575), 0, none_res);
		add_row(mk_item(FN_TICK, 0, 0, 0, 0), 0, none_res);
		add_row(mk_item(FN_ROLLER_TIME, 0, 0, -4096, 10), 0, none_res);
		add_row(mk_item(FN_INTAKE_TIME, 0, 0, 4095, 0), 0, none_res);
		add_row(mk_item(FN_ROLLER_SPEED, 0, 0, 1, 0), 0, none_res);
		// unused function code
		add_row(mk_item(FN_UNUSED, 1, -1, -1, -1), 0, none_res);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			drive_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
		drain_results();

		// Random phases, each under its own config; phase 0 keeps reset values
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       begin ms = RESET_MAX_SPEED; ig = RESET_GAIN; rg = RESET_GAIN; end
				1:       begin ms = 0;   ig = 0;     rg = 0;     end
				2:       begin ms = 600; ig = 65535; rg = 65535; end
				3:       begin ms = 600; ig = 256;   rg = 256;   end
				5:       begin ms = 1;   ig = 1;     rg = 65535; end
				7:       begin ms = 200; ig = 512;   rg = 128;   end
				default: begin
					ms = $urandom_range(0, 600);
					ig = $urandom_range(0, 65535);
					rg = $urandom_range(0, 65535);
				end
			endcase
			if (p != 0)
				program_cfg(ms, ig, rg, p == 1);
			calm = (p == 3);
			if (p == 5)
				stall_asks++;   // receiver holds off while the sender keeps offering
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				build_sequence();
				while (item_q.size() != 0) begin
					drive_item(item_q.pop_front(), 0, none_res);
					sent++;
				end
			end
			drain_results();
		end

		if (mismatches == 0)
			$display("PASS catapult_intake_sequencer_core");
		else
			$display("FAIL catapult_intake_sequencer_core");
		$finish;
	end

	// Watchdog well beyond the slowest legal run
	initial begin : watchdog
		#3000000;
		$display("FAIL catapult_intake_sequencer_core");
		$finish;
	end

endmodule
